/* design/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    // Output word geometry
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned FILL_W    = 5;
    localparam logic [FILL_W-1:0] FILL_LAST = 5'd31;

    // Configuration port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // Request mode codes
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_START  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Control from the sequencer to the packer
    typedef struct packed {
        logic start;
        logic load;
        logic step;
    } pk_ctl_t;

    // Status from the packer back to the sequencer
    typedef struct packed {
        logic last;       // next bit completes the word
        logic final_bit;  // next bit is the last bit of the code
    } pk_stat_t;

endpackage

/* design/hcbp_table.sv */
// ----------------------------------------------------------------------------
// hcbp_table
// Per-symbol code table: code and length memory with registered read,
// valid marks in flip-flops cleared at reset.
// ----------------------------------------------------------------------------
module hcbp_table #(
    parameter int SYMBOL_COUNT  = 256,
    parameter int MAX_CODE_BITS = 32,
    parameter int AW = $clog2(SYMBOL_COUNT),
    parameter int LW = $clog2(MAX_CODE_BITS + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [MAX_CODE_BITS-1:0] wcode,
    input  logic [LW-1:0]            wlen,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic                     rd_valid,
    output logic [MAX_CODE_BITS-1:0] rd_code,
    output logic [LW-1:0]            rd_len
);

    logic [MAX_CODE_BITS-1:0] code_mem [SYMBOL_COUNT];
    logic [LW-1:0]            len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]  valid_reg;

    logic                     rd_valid_reg;
    logic [MAX_CODE_BITS-1:0] rd_code_reg;
    logic [LW-1:0]            rd_len_reg;

    // valid marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // code and length store
    always_ff @(posedge aclk) begin
        if (we) begin
            code_mem[waddr] <= wcode;
            len_mem[waddr]  <= wlen;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_valid_reg <= valid_reg[raddr];
            rd_code_reg  <= code_mem[raddr];
            rd_len_reg   <= len_mem[raddr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_code  = rd_code_reg;
    assign rd_len   = rd_len_reg;

endmodule

/* design/hcbp_packer.sv */
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit-serial packer: shifts one code bit per step into a 32-bit word
// shift register, earlier bits ending nearer the most significant end.
// ----------------------------------------------------------------------------
module hcbp_packer #(
    parameter int MAX_CODE_BITS = 32,
    parameter int LW = $clog2(MAX_CODE_BITS + 1),
    parameter int IW = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  hcbp_pkg::pk_ctl_t                 ctl,
    input  logic [hcbp_pkg::FILL_W-1:0]       pad,
    input  logic [MAX_CODE_BITS-1:0]          code,
    input  logic [LW-1:0]                     len,
    output hcbp_pkg::pk_stat_t                stat,
    output logic [hcbp_pkg::WORD_BITS-1:0]    word
);

    logic [hcbp_pkg::WORD_BITS-1:0] buf_reg;
    logic [hcbp_pkg::FILL_W-1:0]    fill_reg;
    logic [MAX_CODE_BITS-1:0]       code_reg;
    logic [LW-1:0]                  k_reg;
    logic [LW-1:0]                  k_dec;
    logic                           cur_bit;

    // k counts down; the bit sent is code bit k-1
    assign k_dec   = k_reg - LW'(1);
    assign cur_bit = code_reg[k_dec[IW-1:0]];
    assign word    = {buf_reg[hcbp_pkg::WORD_BITS-2:0], cur_bit};

    assign stat.last      = (fill_reg == hcbp_pkg::FILL_LAST);
    assign stat.final_bit = (k_reg == LW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            fill_reg <= '0;
            k_reg    <= '0;
        end else begin
            if (ctl.start) begin
                buf_reg  <= '0;
                fill_reg <= pad;
            end
            if (ctl.load) begin
                k_reg <= len;
            end
            if (ctl.step) begin
                // drop the word once it is full, else shift the bit in
                buf_reg  <= stat.last ? '0 : word;
                fill_reg <= fill_reg + hcbp_pkg::FILL_W'(1);
                k_reg    <= k_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            code_reg <= code;
        end
    end

endmodule

/* design/huffman_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder back end: per-symbol code table, bit-serial packing of
// codes into 32-bit words, at most one word or one error flag per encode request.
// ----------------------------------------------------------------------------
// Timing: load, start and unused requests complete in IDLE. An encode request
//   reads the table (registered), then LOOKUP hands the stored code of length
//   L to the packer, which shifts it out one bit per step; a word or error
//   appears on m_valid the cycle after the bit or lookup that produces it.
// Throughput: requests are taken only in IDLE, so an encode request holds off
//   the next until its last bit. The packer sends one bit per cycle; a busy
//   output holds the sequencer only at a bit that completes a word or at an
//   unknown-symbol lookup, for as long as the waiting word stays untaken.
// Reset (aresetn low, synchronous): valid marks, buffer, fill and pad clear.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
    parameter int MAX_CODE_BITS = 32,
    parameter int SYMBOL_COUNT  = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_symbol,
    input  logic [31:0] s_code_value,
    input  logic [5:0]  s_code_length,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_packed_word,
    output logic        m_unknown_symbol,

    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hcbp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hcbp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hcbp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int AW = $clog2(SYMBOL_COUNT);
    localparam int LW = $clog2(MAX_CODE_BITS + 1);
    localparam logic [8:0] SYM_LIMIT = 9'(SYMBOL_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SHIFT
    } state_t;

    state_t state_reg, state_next;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_word_reg, m_word_next;
    logic        m_unk_reg, m_unk_next;

    logic [hcbp_pkg::FILL_W-1:0] pad_reg;
    logic                        sym_ok_reg;

    logic                  s_accept;
    logic                  out_free;
    logic                  sym_in_range;
    hcbp_pkg::mode_t       req_mode;
    logic [LW-1:0]         len_sat;

    logic                     tbl_we;
    logic                     tbl_re;
    logic                     rd_valid;
    logic [MAX_CODE_BITS-1:0] rd_code;
    logic [LW-1:0]            rd_len;

    hcbp_pkg::pk_ctl_t          pk_ctl;
    hcbp_pkg::pk_stat_t         pk_stat;
    logic [hcbp_pkg::WORD_BITS-1:0] pk_word;

    // ------------------------------------------------------------------
    // Configuration: a single register, pad_bits, at byte address 0.
    // Address bit 2 set points beyond the register list; writes there
    // are dropped and reads return zero.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_reg <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            pad_reg <= pwdata[hcbp_pkg::FILL_W-1:0];
        end
    end

    assign prdata = paddr[2] ? '0 : hcbp_pkg::APB_DATA_W'(pad_reg);

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign s_ready      = (state_reg == ST_IDLE);
    assign s_accept     = s_valid && s_ready;
    assign req_mode     = hcbp_pkg::mode_t'(s_mode);
    assign sym_in_range = ({1'b0, s_symbol} < SYM_LIMIT);

    // saturate the loaded length to the widest code the table holds
    assign len_sat = (s_code_length > 6'(MAX_CODE_BITS)) ? LW'(MAX_CODE_BITS)
                                                         : LW'(s_code_length);

    // a symbol beyond the table reads as unknown; hold the verdict
    // alongside the registered table read
    always_ff @(posedge aclk) begin
        if (tbl_re) begin
            sym_ok_reg <= sym_in_range;
        end
    end

    // Output register: a finished word waits here while the next request
    // is taken. It is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Sequencer
    // IDLE   : take a request; load and start complete here.
    // LOOKUP : table data is valid; flag an unknown symbol or hand the
    //          code to the packer.
    // SHIFT  : advance one code bit per cycle; hold only when this bit
    //          completes a word and the output register is still full.
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        m_unk_next   = m_unk_reg;
        tbl_we       = 1'b0;
        tbl_re       = 1'b0;
        pk_ctl       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (req_mode)
                        hcbp_pkg::MODE_LOAD: begin
                            tbl_we = sym_in_range;
                        end
                        hcbp_pkg::MODE_ENCODE: begin
                            tbl_re     = 1'b1;
                            state_next = ST_LOOKUP;
                        end
                        hcbp_pkg::MODE_START: begin
                            pk_ctl.start = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (!sym_ok_reg || !rd_valid) begin
                    // unknown symbol: error result, buffer untouched
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_word_next  = '0;
                        m_unk_next   = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    pk_ctl.load = 1'b1;
                    // an empty code adds no bits
                    state_next  = (rd_len == '0) ? ST_IDLE : ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (!pk_stat.last || out_free) begin
                    pk_ctl.step = 1'b1;
                    if (pk_stat.last) begin
                        m_valid_next = 1'b1;
                        m_word_next  = pk_word;
                        m_unk_next   = 1'b0;
                    end
                    if (pk_stat.final_bit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        m_word_reg <= m_word_next;
        m_unk_reg  <= m_unk_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_packed_word    = m_word_reg;
    assign m_unknown_symbol = m_unk_reg;

    // ------------------------------------------------------------------
    // Code table and packer
    // ------------------------------------------------------------------
    hcbp_table #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .we       (tbl_we),
        .waddr    (s_symbol[AW-1:0]),
        .wcode    (s_code_value[MAX_CODE_BITS-1:0]),
        .wlen     (len_sat),
        .re       (tbl_re),
        .raddr    (s_symbol[AW-1:0]),
        .rd_valid (rd_valid),
        .rd_code  (rd_code),
        .rd_len   (rd_len)
    );

    hcbp_packer #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (pk_ctl),
        .pad     (pad_reg),
        .code    (rd_code),
        .len     (rd_len),
        .stat    (pk_stat),
        .word    (pk_word)
    );

endmodule
